### hdl/pctd_pkg.sv
// shared constants and types for the trial-division prime counter
`timescale 1ns / 1ps

package pctd_pkg;

    // input value and tally widths
    localparam int VALUE_W = 32;
    localparam int MAG_W   = VALUE_W - 1;
    localparam int TALLY_W = 32;

    // trial divisor never exceeds 46341, square stays below 2^32
    localparam int DIV_W     = 16;
    localparam int SQ_W      = 32;
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [DIV_W-1:0]   FIRST_DIV = DIV_W'(2);
    localparam logic [SQ_W-1:0]    FIRST_SQ  = SQ_W'(4);

    // verdict handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        logic prime;
    } pctd_verdict_t;

endpackage

### hdl/pctd_rem_unit.sv
// shared restoring divider that forms the remainder one bit per cycle
`timescale 1ns / 1ps

module pctd_rem_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pctd_pkg::MAG_W-1:0] dividend,
    input  logic [pctd_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic                       rem_zero
);
    import pctd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MAG_W-1:0]    dvd_reg, dvd_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W:0]      rem_shift;
    logic [DIV_W:0]      rem_diff;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[MAG_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, divisor})
                rem_next = rem_diff[DIV_W-1:0];
            else
                rem_next = rem_shift[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

### hdl/pctd_ctrl.sv
// sequencer that walks trial divisors and keeps the running square
`timescale 1ns / 1ps

module pctd_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pctd_pkg::VALUE_W-1:0] value,
    input  logic                         take,
    output logic                         idle,
    output pctd_pkg::pctd_verdict_t      verdict,
    output logic                         div_start,
    output logic [pctd_pkg::MAG_W-1:0]   div_dividend,
    output logic [pctd_pkg::DIV_W-1:0]   div_divisor,
    input  logic                         div_done,
    input  logic                         div_rem_zero
);
    import pctd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             prime_reg, prime_next;
    logic [MAG_W-1:0] v_reg, v_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]  dsq_reg, dsq_next;
    logic             trivial;

    // negative, zero and one are never prime
    assign trivial = value[VALUE_W-1] || (value[MAG_W-1:0] <= MAG_W'(1));

    always_comb
    begin
        state_next = state_reg;
        prime_next = prime_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        dsq_next   = dsq_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    v_next   = value[MAG_W-1:0];
                    d_next   = FIRST_DIV;
                    dsq_next = FIRST_SQ;
                    if (trivial)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // divisor past the square root: no factor found
                if (dsq_reg > {1'b0, v_reg})
                begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + DIV_W'(1);
                        dsq_next   = dsq_reg + SQ_W'({d_reg, 1'b1});
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        v_reg     <= v_next;
        d_reg     <= d_next;
        dsq_reg   <= dsq_next;
    end

    assign idle          = (state_reg == ST_IDLE);
    assign verdict.valid = (state_reg == ST_DONE);
    assign verdict.prime = prime_reg;
    assign div_dividend  = v_reg;
    assign div_divisor   = d_reg;

endmodule

### hdl/prime_count_trial_division_unit.sv
// top level: trial-division primality test with a saturating prime tally
`timescale 1ns / 1ps
//
// channel   direction  tdata                   tuser
// s_axis    in         [31:0] value (signed)   -
// m_axis    out        [31:0] prime_total      [0] is_prime
//
// values below 2 skip the trial divisions and go straight to the done state
// each trial divisor takes one pass through the shared bit-serial remainder unit,
// so a prime v, the worst case, runs all floor(sqrt(v)) - 1 trial divisors
// one item is in work at a time; s_axis_tready is low from accept until the
// result moves into the output register, which may still hold a stalled result
// reset clears the tally, the sequencer and the output valid; no clearing pass

module prime_count_trial_division_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pctd_pkg::VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pctd_pkg::TALLY_W-1:0] m_axis_tdata,   // [31:0] prime_total
    output logic                         m_axis_tuser    // [0] is_prime
);
    import pctd_pkg::*;

    logic               accept;
    logic               take;
    logic               load;
    logic               idle;
    pctd_verdict_t      verdict;
    logic               div_start;
    logic [MAG_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic               div_rem_zero;

    logic               out_valid_reg, out_valid_next;
    logic               out_prime_reg, out_prime_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;

    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = !out_valid_reg || m_axis_tready;
    assign load          = verdict.valid && take;

    pctd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .value        (s_axis_tdata),
        .take         (take),
        .idle         (idle),
        .verdict      (verdict),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_rem_zero (div_rem_zero)
    );

    pctd_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem_zero (div_rem_zero)
    );

    // tally update and output register
    always_comb
    begin
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        if (load)
        begin
            if (verdict.prime && (tally_reg != TALLY_MAX))
                tally_next = tally_reg + TALLY_W'(1);
            out_valid_next = 1'b1;
            out_prime_next = verdict.prime;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tally_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tally_reg     <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prime_reg <= out_prime_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_prime_reg;
    assign m_axis_tdata  = tally_reg;

`ifndef SYNTH
    // tally moves by at most one per cycle and never down
    a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tally_reg == $past(tally_reg)) || (tally_reg == $past(tally_reg) + TALLY_W'(1)))
        else $error("tally jumped");

    // a reported prime means the tally is nonzero
    a_prime_tally: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (tally_reg != '0))
        else $error("prime reported with zero tally");

    // no new transaction is taken while the sequencer holds a verdict
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> !s_axis_tready)
        else $error("input accepted while verdict pending");

    // the tally only changes when a verdict is loaded
    a_tally_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(tally_reg))
        else $error("tally changed without a result");
`endif

endmodule
